### rtl/nv3d_pkg.sv
// ----------------------------------------------------------------------------
// nv3d_pkg: shared types and constants
// Widths and sideband types used by the 3D vector normalizer modules.
// ----------------------------------------------------------------------------
package nv3d_pkg;

  localparam int FRAC_BITS  = 16;
  localparam int COMP_WIDTH = 24;
  localparam int THR_WIDTH  = 24;

  // Sum of three squares of magnitudes up to 2^(COMP_WIDTH-1) fits in 2*COMP_WIDTH bits.
  localparam int SUM_W  = 2 * COMP_WIDTH;
  localparam int ROOT_W = COMP_WIDTH;
  localparam int SQC_W  = SUM_W + 1;
  // Quotient magnitude is at most 2^FRAC_BITS.
  localparam int Q_W    = FRAC_BITS + 1;
  localparam int DIVD_W = COMP_WIDTH + FRAC_BITS;

  localparam int PRE_STAGES = 3;
  localparam int LAT = PRE_STAGES + ROOT_W + Q_W + 1;

  typedef struct packed {
    logic [2:0][COMP_WIDTH-1:0] raw;
    logic [2:0][COMP_WIDTH-1:0] mag;
  } side_t;

  typedef struct packed {
    logic [2:0][COMP_WIDTH-1:0] raw;
    logic                       pass;
  } dside_t;

endpackage

### rtl/nv3d_if.sv
// ----------------------------------------------------------------------------
// nv3d interfaces
// Valid/ready channels for the input vector word and the result word.
// ----------------------------------------------------------------------------
interface nv3d_in_if import nv3d_pkg::*; ();
  logic                         valid;
  logic                         ready;
  logic signed [COMP_WIDTH-1:0] in_x;
  logic signed [COMP_WIDTH-1:0] in_y;
  logic signed [COMP_WIDTH-1:0] in_z;
  modport source (output valid, output in_x, output in_y, output in_z, input ready);
  modport sink   (input valid, input in_x, input in_y, input in_z, output ready);
endinterface

interface nv3d_out_if import nv3d_pkg::*; ();
  logic                         valid;
  logic                         ready;
  logic signed [COMP_WIDTH-1:0] out_x;
  logic signed [COMP_WIDTH-1:0] out_y;
  logic signed [COMP_WIDTH-1:0] out_z;
  logic                         passed_unchanged;
  modport source (output valid, output out_x, output out_y, output out_z,
                  output passed_unchanged, input ready);
  modport sink   (input valid, input out_x, input out_y, input out_z,
                  input passed_unchanged, output ready);
endinterface

### rtl/nv3d_sqrt.sv
// ----------------------------------------------------------------------------
// nv3d_sqrt: pipelined integer square root
// One root bit per stage; the sideband travels alongside.
// ----------------------------------------------------------------------------
module nv3d_sqrt import nv3d_pkg::*; (
  input  logic              clk,
  input  logic              en,
  input  logic [SUM_W-1:0]  sum_i,
  input  side_t             side_i,
  output logic [ROOT_W-1:0] root_o,
  output side_t             side_o
);

  logic [SUM_W-1:0]  rem_r  [ROOT_W];
  logic [ROOT_W-1:0] root_r [ROOT_W];
  side_t             side_r [ROOT_W];

  for (genvar s = 0; s < ROOT_W; s++) begin : g_stage
    localparam int K = ROOT_W - 1 - s;
    logic [SUM_W-1:0]  rem_in;
    logic [ROOT_W-1:0] root_in;
    side_t             side_in;
    logic [SQC_W-1:0]  cand;
    logic [SUM_W-1:0]  rem_nxt;
    logic [ROOT_W-1:0] root_nxt;

    if (s == 0) begin : g_first
      assign rem_in  = sum_i;
      assign root_in = '0;
      assign side_in = side_i;
    end else begin : g_next
      assign rem_in  = rem_r[s-1];
      assign root_in = root_r[s-1];
      assign side_in = side_r[s-1];
    end

    // Remainder holds v - root^2; adding bit K grows the square by this amount.
    always_comb begin
      cand = (SQC_W'(root_in) << (K + 1)) | (SQC_W'(1) << (2 * K));
      if ({1'b0, rem_in} >= cand) begin
        rem_nxt  = SUM_W'({1'b0, rem_in} - cand);
        root_nxt = root_in | (ROOT_W'(1) << K);
      end else begin
        rem_nxt  = rem_in;
        root_nxt = root_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[s]  <= rem_nxt;
        root_r[s] <= root_nxt;
        side_r[s] <= side_in;
      end
    end
  end

  assign root_o = root_r[ROOT_W-1];
  assign side_o = side_r[ROOT_W-1];

endmodule

### rtl/nv3d_div_lane.sv
// ----------------------------------------------------------------------------
// nv3d_div_lane: pipelined restoring divider for one component
// Computes (mag << FRAC_BITS) / len, one quotient bit per stage.
// ----------------------------------------------------------------------------
module nv3d_div_lane import nv3d_pkg::*; (
  input  logic                  clk,
  input  logic                  en,
  input  logic [COMP_WIDTH-1:0] mag_i,
  input  logic [ROOT_W-1:0]     len_i,
  output logic [Q_W-1:0]        q_o
);

  logic [DIVD_W-1:0] rem_r [Q_W];
  logic [Q_W-1:0]    q_r   [Q_W];
  logic [ROOT_W-1:0] d_r   [Q_W];

  for (genvar j = 0; j < Q_W; j++) begin : g_stage
    localparam int B = Q_W - 1 - j;
    logic [DIVD_W-1:0] rem_in;
    logic [Q_W-1:0]    q_in;
    logic [ROOT_W-1:0] d_in;
    logic [DIVD_W:0]   sub;
    logic [DIVD_W-1:0] rem_nxt;
    logic [Q_W-1:0]    q_nxt;

    if (j == 0) begin : g_first
      assign rem_in = {mag_i, {FRAC_BITS{1'b0}}};
      assign q_in   = '0;
      assign d_in   = len_i;
    end else begin : g_next
      assign rem_in = rem_r[j-1];
      assign q_in   = q_r[j-1];
      assign d_in   = d_r[j-1];
    end

    always_comb begin
      sub = (DIVD_W+1)'(d_in) << B;
      if ({1'b0, rem_in} >= sub) begin
        rem_nxt = DIVD_W'({1'b0, rem_in} - sub);
        q_nxt   = q_in | (Q_W'(1) << B);
      end else begin
        rem_nxt = rem_in;
        q_nxt   = q_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[j] <= rem_nxt;
        q_r[j]   <= q_nxt;
        d_r[j]   <= d_in;
      end
    end
  end

  assign q_o = q_r[Q_W-1];

endmodule

### rtl/normalize_vector_3d_top.sv
// ----------------------------------------------------------------------------
// normalize_vector_3d_top: 3D fixed-point vector normalizer
// Pipeline from an accepted input word to its result word:
//   3 front stages, 24 square-root stages, 17 divider stages, output register.
// Throughput: one word per cycle; the whole pipeline stalls only while the
//   output register holds a word that the sink does not take.
// Reset (rst_n low, synchronous) empties the pipeline and clears the threshold.
// ----------------------------------------------------------------------------
module normalize_vector_3d_top import nv3d_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [THR_WIDTH-1:0] cfg_wdata,
  nv3d_in_if.sink              in_vec,
  nv3d_out_if.source           out_vec
);

  // The pipeline advances as a whole. It moves whenever the output register is
  // empty or is being drained, so a new word enters every cycle in steady flow.
  logic           en;
  logic [LAT-1:0] v_r;
  logic [THR_WIDTH-1:0] thr_r;

  assign en           = !v_r[LAT-1] || out_vec.ready;
  assign in_vec.ready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r   <= '0;
      thr_r <= '0;
    end else begin
      if (en) begin
        v_r <= {v_r[LAT-2:0], in_vec.valid};
      end
      if (cfg_we) begin
        thr_r <= cfg_wdata;
      end
    end
  end

  // Stage 1: component magnitudes. The most negative code maps to 2^(W-1),
  // which still fits the unsigned width.
  logic [2:0][COMP_WIDTH-1:0] raw_in;
  logic [2:0][COMP_WIDTH-1:0] mag_nxt;
  side_t                      s1_r, s2_r, s3_r;
  logic [2:0][SUM_W-1:0]      sq_r;
  logic [SUM_W-1:0]           sum_r;

  assign raw_in = {in_vec.in_z, in_vec.in_y, in_vec.in_x};

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      mag_nxt[i] = raw_in[i][COMP_WIDTH-1] ? COMP_WIDTH'(-raw_in[i]) : raw_in[i];
    end
  end

  // Stages 2 and 3: one multiplier per component, then the three-way sum.
  always_ff @(posedge clk) begin
    if (en) begin
      s1_r.raw <= raw_in;
      s1_r.mag <= mag_nxt;
      for (int i = 0; i < 3; i++) begin
        sq_r[i] <= s1_r.mag[i] * s1_r.mag[i];
      end
      s2_r  <= s1_r;
      sum_r <= sq_r[0] + sq_r[1] + sq_r[2];
      s3_r  <= s2_r;
    end
  end

  // Square root: length of the vector in the component format.
  logic [ROOT_W-1:0] len;
  side_t             sq_side;

  nv3d_sqrt u_sqrt (
    .clk    (clk),
    .en     (en),
    .sum_i  (sum_r),
    .side_i (s3_r),
    .root_o (len),
    .side_o (sq_side)
  );

  // Three divider lanes, one per component. A vector at or below the threshold
  // still runs through them; its quotients are simply not used.
  logic [2:0][Q_W-1:0] q;

  for (genvar i = 0; i < 3; i++) begin : g_lane
    nv3d_div_lane u_lane (
      .clk   (clk),
      .en    (en),
      .mag_i (sq_side.mag[i]),
      .len_i (len),
      .q_o   (q[i])
    );
  end

  // The raw components and the pass-through decision ride beside the lanes.
  dside_t dd_r [Q_W];

  always_ff @(posedge clk) begin
    if (en) begin
      dd_r[0].raw  <= sq_side.raw;
      dd_r[0].pass <= ({{(THR_WIDTH-ROOT_W){1'b0}}, len} <= thr_r);
      for (int j = 1; j < Q_W; j++) begin
        dd_r[j] <= dd_r[j-1];
      end
    end
  end

  // Merge stage: restore signs, or pass the input through unchanged.
  logic [2:0][COMP_WIDTH-1:0] res_nxt;
  logic [2:0][COMP_WIDTH-1:0] res_r;
  logic                       pass_r;
  logic [COMP_WIDTH-1:0]      qx;

  always_comb begin
    qx = '0;
    for (int i = 0; i < 3; i++) begin
      qx = COMP_WIDTH'(q[i]);
      if (dd_r[Q_W-1].pass) begin
        res_nxt[i] = dd_r[Q_W-1].raw[i];
      end else if (dd_r[Q_W-1].raw[i][COMP_WIDTH-1]) begin
        res_nxt[i] = -qx;
      end else begin
        res_nxt[i] = qx;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res_r  <= res_nxt;
      pass_r <= dd_r[Q_W-1].pass;
    end
  end

  assign out_vec.valid            = v_r[LAT-1];
  assign out_vec.out_x            = res_r[0];
  assign out_vec.out_y            = res_r[1];
  assign out_vec.out_z            = res_r[2];
  assign out_vec.passed_unchanged = pass_r;

  localparam logic signed [COMP_WIDTH-1:0] UNIT = COMP_WIDTH'(1) << FRAC_BITS;

  // A normalized component never exceeds one in magnitude.
  a_unit_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_vec.valid && !out_vec.passed_unchanged |->
      (out_vec.out_x <= UNIT) && (out_vec.out_x >= -UNIT) &&
      (out_vec.out_y <= UNIT) && (out_vec.out_y >= -UNIT) &&
      (out_vec.out_z <= UNIT) && (out_vec.out_z >= -UNIT))
    else $error("normalized component out of range");

  // A stalled output register blocks new input.
  a_stall_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    out_vec.valid && !out_vec.ready |-> !in_vec.ready)
    else $error("input accepted while output stalled");

  // A word in the last pipeline stage reaches the output register on advance.
  a_advance: assert property (@(posedge clk) disable iff (!rst_n)
    en && v_r[LAT-2] |=> out_vec.valid)
    else $error("word lost before output register");

endmodule

### dv/nv3d_tb_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Testbench interface notes
// The channels are the RTL interfaces nv3d_in_if and nv3d_out_if; this file
// holds only a small package with testbench-side constants.
// ----------------------------------------------------------------------------
package nv3d_tb_pkg;
  localparam int MAX_GAP      = 18;
  localparam int WATCHDOG_MAX = 20000;
endpackage

### dv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: 3D vector normalizer
// Drives vectors through the valid/ready input channel, predicts each
// normalized or passed-through word in the testbench, and checks every result
// word field by field; both sides idle in random bursts but in the last phase.
// ----------------------------------------------------------------------------
module testbench;
  import nv3d_pkg::*;
  import nv3d_tb_pkg::*;

  typedef struct packed {
    logic signed [COMP_WIDTH-1:0] x;
    logic signed [COMP_WIDTH-1:0] y;
    logic signed [COMP_WIDTH-1:0] z;
    logic                         pass;
  } unit_vec_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [THR_WIDTH-1:0] cfg_wdata = '0;

  nv3d_in_if  in_vec ();
  nv3d_out_if out_vec ();

  normalize_vector_3d_top i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_vec    (in_vec.sink),
    .out_vec   (out_vec.source)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Threshold as the predictor sees it, plus the queue of predicted words.
  logic [THR_WIDTH-1:0] threshold_model = '0;
  unit_vec_t unit_vec_q[$];
  int errors = 0;
  int words_sent = 0;
  int words_checked = 0;
  int pass_count = 0;
  int idle_cycles = 0;
  bit idle_enable = 1'b1;

  initial begin
    in_vec.valid = 1'b0;
    in_vec.in_x = '0;
    in_vec.in_y = '0;
    in_vec.in_z = '0;
    out_vec.ready = 1'b0;
  end

  // Floor square root of a 48-bit sum, bit by bit.
  function automatic logic [ROOT_W-1:0] floor_root(input logic [SUM_W-1:0] v);
    logic [SUM_W+1:0] rem;
    logic [SUM_W+1:0] res;
    logic [SUM_W+1:0] bitv;
    rem = {2'b00, v};
    res = '0;
    bitv = (SUM_W+2)'(1) << (SUM_W - 2);
    while (bitv > rem) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (rem >= res + bitv) begin
        rem = rem - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res[ROOT_W-1:0];
  endfunction

  // Normalizes a vector (magnitude, root, truncating divide) or passes it on.
  function automatic unit_vec_t normalize(input logic signed [COMP_WIDTH-1:0] x,
                                          input logic signed [COMP_WIDTH-1:0] y,
                                          input logic signed [COMP_WIDTH-1:0] z);
    logic signed [COMP_WIDTH-1:0] comp[3];
    logic [COMP_WIDTH:0] mag[3];
    logic [SUM_W-1:0] sum;
    logic [ROOT_W-1:0] len;
    logic [DIVD_W:0] quo;
    logic [COMP_WIDTH-1:0] res[3];
    unit_vec_t r;
    comp[0] = x; comp[1] = y; comp[2] = z;
    sum = '0;
    for (int i = 0; i < 3; i++) begin
      mag[i] = comp[i] < 0 ? -$signed({comp[i][COMP_WIDTH-1], comp[i]}) : comp[i];
      sum = sum + mag[i] * mag[i];
    end
    len = floor_root(sum);
    if (len <= threshold_model) begin
      r.x = x; r.y = y; r.z = z; r.pass = 1'b1;
    end else begin
      for (int i = 0; i < 3; i++) begin
        quo = ({{(DIVD_W - COMP_WIDTH){1'b0}}, mag[i]} << FRAC_BITS) / len;
        res[i] = comp[i] < 0 ? -quo[COMP_WIDTH-1:0] : quo[COMP_WIDTH-1:0];
      end
      r.x = res[0]; r.y = res[1]; r.z = res[2]; r.pass = 1'b0;
    end
    return r;
  endfunction

  // Sends one word: optional idle burst, then hold valid until accepted.
  // Valid stays high on return; the next caller either reloads it or drops it.
  task automatic send_vector(input logic [COMP_WIDTH-1:0] x,
                             input logic [COMP_WIDTH-1:0] y,
                             input logic [COMP_WIDTH-1:0] z);
    if (idle_enable && $urandom_range(0, 3) == 0) begin
      in_vec.valid <= 1'b0;
      repeat ($urandom_range(1, MAX_GAP)) @(negedge clk);
    end
    in_vec.valid <= 1'b1;
    in_vec.in_x <= x;
    in_vec.in_y <= y;
    in_vec.in_z <= z;
    @(posedge clk);
    while (!in_vec.ready) @(posedge clk);
    unit_vec_q.push_back(normalize(x, y, z));
    words_sent++;
    @(negedge clk);
  endtask

  // Waits for the pipeline to drain, then writes the threshold register.
  task automatic write_threshold(input logic [THR_WIDTH-1:0] thr);
    in_vec.valid <= 1'b0;
    while (unit_vec_q.size() != 0) @(negedge clk);
    repeat (LAT + 5) @(negedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= thr;
    @(negedge clk);
    cfg_we <= 1'b0;
    threshold_model = thr;
  endtask

  function automatic logic [COMP_WIDTH-1:0] rand_comp();
    case ($urandom_range(0, 5))
      0: return COMP_WIDTH'($urandom_range(0, 255) - 128);
      1: return {1'b1, {(COMP_WIDTH-1){1'b0}}};
      2: return {1'b0, {(COMP_WIDTH-1){1'b1}}};
      default: return COMP_WIDTH'($urandom());
    endcase
  endfunction

  // Result sink: random stall bursts, sample at the rising edge.
  initial begin
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (idle_enable && $urandom_range(0, 7) == 0) begin
        out_vec.ready <= 1'b0;
        repeat ($urandom_range(1, MAX_GAP)) @(negedge clk);
      end
      out_vec.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    unit_vec_t exp_w;
    if (rst_n && out_vec.valid && out_vec.ready) begin
      if (unit_vec_q.size() == 0) begin
        $error("result word with no prediction waiting");
        errors++;
      end else begin
        exp_w = unit_vec_q.pop_front();
        words_checked++;
        if (exp_w.pass) pass_count++;
        if (out_vec.out_x !== exp_w.x) begin
          $error("out_x expected %0d actual %0d", exp_w.x, out_vec.out_x); errors++;
        end
        if (out_vec.out_y !== exp_w.y) begin
          $error("out_y expected %0d actual %0d", exp_w.y, out_vec.out_y); errors++;
        end
        if (out_vec.out_z !== exp_w.z) begin
          $error("out_z expected %0d actual %0d", exp_w.z, out_vec.out_z); errors++;
        end
        if (out_vec.passed_unchanged !== exp_w.pass) begin
          $error("passed_unchanged expected %0d actual %0d",
                 exp_w.pass, out_vec.passed_unchanged);
          errors++;
        end
      end
    end
  end

  // Watchdog: cycles with no word accepted on either side.
  always @(posedge clk) begin
    if ((in_vec.valid && in_vec.ready) || (out_vec.valid && out_vec.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles > WATCHDOG_MAX) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Extremes, zero vector and single-axis vectors at reset threshold.
  task automatic test_directed();
    logic [COMP_WIDTH-1:0] mx;
    logic [COMP_WIDTH-1:0] mn;
    mx = {1'b0, {(COMP_WIDTH-1){1'b1}}};
    mn = {1'b1, {(COMP_WIDTH-1){1'b0}}};
    send_vector('0, '0, '0);
    send_vector(mx, mx, mx);
    send_vector(mn, mn, mn);
    send_vector(mn, '0, '0);
    send_vector('0, mn, '0);
    send_vector('0, '0, mx);
    send_vector(mx, mn, COMP_WIDTH'(1));
    send_vector(COMP_WIDTH'(1), '0, '0);
    send_vector('1, '1, '1);
    send_vector(24'h010000, '0, '0);
    send_vector(24'h030000, 24'h040000, '0);
    send_vector(-24'sd196608, 24'h040000, -24'sd786432);
    send_vector(24'hAAAAAA, 24'h555555, 24'hFFFFFF);
  endtask

  function automatic logic [COMP_WIDTH-1:0] mn_vec();
    return {1'b1, {(COMP_WIDTH-1){1'b0}}};
  endfunction

  // Threshold sweep with short vectors so both outcomes appear.
  task automatic test_threshold();
    logic [THR_WIDTH-1:0] thr_set[4];
    thr_set = '{24'hFFFFFF, 24'd256, 24'h010000, 24'd0};
    foreach (thr_set[k]) begin
      write_threshold(thr_set[k]);
      send_vector(24'd256, '0, '0);
      send_vector(24'd257, '0, '0);
      send_vector(mn_vec(), '0, '0);
      repeat (20) send_vector(rand_comp(), rand_comp(), rand_comp());
    end
  endtask

  // Random vectors under random thresholds; last part runs with no idling.
  task automatic test_random();
    for (int ph = 0; ph < 5; ph++) begin
      write_threshold(ph[0] ? THR_WIDTH'($urandom_range(0, 24'h030000))
                            : THR_WIDTH'($urandom()));
      repeat (200) send_vector(rand_comp(), rand_comp(), rand_comp());
    end
    idle_enable = 1'b0;
    repeat (100) send_vector(rand_comp(), rand_comp(), rand_comp());
  endtask

  initial begin
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    test_directed();
    test_threshold();
    test_random();
    in_vec.valid <= 1'b0;
    while (unit_vec_q.size() != 0) @(negedge clk);
    repeat (LAT + 10) @(negedge clk);
    $display("Sent %0d vectors, checked %0d results, %0d passed through unchanged.",
             words_sent, words_checked, pass_count);
    if (errors == 0 && unit_vec_q.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end
endmodule
